// ----- hdl/pcsa_pkg.sv -----
package pcsa_pkg;

   // default build of the block
   localparam int SPECTRUM_BINS_DEF = 257;
   localparam int SAMPLE_BITS_DEF   = 16;

   // magnitudes are scaled below 2^(ROOT_W-1) before the square root
   localparam int ROOT_W = 32;
   localparam int RAD_W  = 2 * ROOT_W;

   // configuration register indexes
   localparam logic CSR_BAND_LIMIT = 1'b0;
   localparam logic CSR_AVG_FRAMES = 1'b1;

   localparam logic [8:0] BAND_LIMIT_RST = 9'd256;
   localparam logic [7:0] AVG_FRAMES_RST = 8'd4;

endpackage

// ----- hdl/pcsa_ram.sv -----
module pcsa_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 257
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write one entry, read one entry with registered data
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule

// ----- hdl/pcsa_sqrt.sv -----
module pcsa_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       go,
   input  logic [pcsa_pkg::RAD_W-1:0] radicand,
   output logic                       done,
   output logic [pcsa_pkg::ROOT_W-1:0] root
);
   import pcsa_pkg::*;

   logic [RAD_W-1:0] x_ff, x_in, r_ff, r_in, bit_ff, bit_in;
   logic             run_ff, run_in, done_ff, done_in;
   logic [RAD_W-1:0] trial;

   assign trial = r_ff + bit_ff;

   // one result bit per cycle, two radicand bits consumed
   always_comb begin
      x_in    = x_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (go) begin
         x_in   = radicand;
         r_in   = '0;
         bit_in = RAD_W'(1) << (RAD_W - 2);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (x_ff >= trial) begin
            x_in = x_ff - trial;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      x_ff   <= x_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = r_ff[ROOT_W-1:0];
endmodule

// ----- hdl/pcsa_div.sv -----
module pcsa_div #(
   parameter int DW = 47,
   parameter int VW = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          go,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);
   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0] quo_ff, quo_in;
   logic [VW-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in, done_ff, done_in;
   logic [VW:0]   trial;
   logic          fits;

   assign trial = {rem_ff, quo_ff[DW-1]};
   assign fits  = trial >= {1'b0, den_ff};

   // restoring division, one quotient bit per cycle
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (go) begin
         quo_in = dividend;
         rem_in = '0;
         den_in = divisor;
         cnt_in = CW'(DW);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = fits ? VW'(trial - {1'b0, den_ff}) : trial[VW-1:0];
         quo_in = {quo_ff[DW-2:0], fits};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// ----- hdl/phat_cross_spectrum_accumulator.sv -----
// GCC-PHAT cross spectrum accumulator. After reset the block sweeps every
// bin of the accumulator memory to zero with busy high. An item is taken
// when start is high and busy is low, and busy stays high until its single
// result beat appears on rsp_valid, which the receiver must take in that
// cycle. Items run one at a time through one square root unit and one
// shared bit-serial divider: a normalized accumulate uses the root and two
// divisions, a served read up to two divisions, while a skipped bin and an
// unserved read use neither.
module phat_cross_spectrum_accumulator #(
   parameter int SPECTRUM_BINS = pcsa_pkg::SPECTRUM_BINS_DEF,
   parameter int SAMPLE_BITS   = pcsa_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_kind,
   input  logic [8:0]                    req_bin_index,
   input  logic signed [SAMPLE_BITS-1:0] req_first_re,
   input  logic signed [SAMPLE_BITS-1:0] req_first_im,
   input  logic signed [SAMPLE_BITS-1:0] req_second_re,
   input  logic signed [SAMPLE_BITS-1:0] req_second_im,
   input  logic                          req_last_bin,
   output logic                          rsp_valid,
   output logic signed [SAMPLE_BITS-1:0] rsp_avg_re,
   output logic signed [SAMPLE_BITS-1:0] rsp_avg_im,
   output logic                          rsp_read_valid,
   output logic                          rsp_ready_res,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [8:0]                    csr_data
);
   import pcsa_pkg::*;

   localparam int SB  = SAMPLE_BITS;
   localparam int ACC = SB + 8;
   localparam int AW  = $clog2(SPECTRUM_BINS);
   localparam int MW  = 2 * SB;
   localparam int PW  = MW + 1;
   localparam int UW  = ROOT_W - 1;
   localparam int DW  = SB + ROOT_W - 1;
   localparam int SW  = $clog2(MW);

   localparam logic [3:0] ST_CLEAR     = 4'd0;
   localparam logic [3:0] ST_IDLE      = 4'd1;
   localparam logic [3:0] ST_MUL       = 4'd2;
   localparam logic [3:0] ST_SUM       = 4'd3;
   localparam logic [3:0] ST_NORM      = 4'd4;
   localparam logic [3:0] ST_SQ        = 4'd5;
   localparam logic [3:0] ST_ROOT_GO   = 4'd6;
   localparam logic [3:0] ST_ROOT      = 4'd7;
   localparam logic [3:0] ST_DIV_RE    = 4'd8;
   localparam logic [3:0] ST_DIV_IM    = 4'd9;
   localparam logic [3:0] ST_ACC_WR    = 4'd10;
   localparam logic [3:0] ST_RD_CHK    = 4'd11;
   localparam logic [3:0] ST_RD_DIV_RE = 4'd12;
   localparam logic [3:0] ST_RD_DIV_IM = 4'd13;
   localparam logic [3:0] ST_RD_WR     = 4'd14;

   localparam logic [DW-1:0] HALF_Q = DW'(1) << (SB - 1);

   // quotient magnitude to a signed sample, saturated
   function automatic logic signed [SB-1:0] clamp_q(input logic [DW-1:0] q, input logic neg);
      logic signed [SB-1:0] res;
      if (q >= HALF_Q) begin
         res = neg ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
      end else begin
         res = neg ? -$signed(q[SB-1:0]) : $signed(q[SB-1:0]);
      end
      return res;
   endfunction

   function automatic logic [DW-1:0] abs_acc(input logic signed [ACC-1:0] v,
                                             input logic [7:0] fc);
      logic [ACC-1:0] mag;
      mag = v[ACC-1] ? ACC'(-v) : ACC'(v);
      return DW'(mag) + DW'(fc >> 1);
   endfunction

   function automatic logic signed [ACC-1:0] sat_add(input logic signed [ACC-1:0] a,
                                                     input logic signed [SB-1:0] b);
      logic signed [ACC:0] s;
      s = {a[ACC-1], a} + (ACC+1)'(b);
      if (s[ACC] != s[ACC-1]) begin
         return s[ACC] ? {1'b1, {(ACC-1){1'b0}}} : {1'b0, {(ACC-1){1'b1}}};
      end
      return s[ACC-1:0];
   endfunction

   logic [3:0]                  state_ff, state_in;
   logic [AW-1:0]               clr_ff, clr_in;
   logic                        last_ff, last_in;
   logic [8:0]                  bin_ff, bin_in;
   logic signed [SB-1:0]        ar_ff, ar_in, ai_ff, ai_in, br_ff, br_in, bi_ff, bi_in;
   logic [8:0]                  band_ff, band_in;
   logic [7:0]                  avgf_ff, avgf_in, fc_ff, fc_in;
   logic signed [ACC-1:0]       accr_ff, accr_in, acci_ff, acci_in;
   logic signed [MW-1:0]        p1_ff, p1_in, p2_ff, p2_in, p3_ff, p3_in, p4_ff, p4_in;
   logic signed [PW-1:0]        cr_ff, cr_in, ci_ff, ci_in;
   logic [UW-1:0]               ur_ff, ur_in, ui_ff, ui_in;
   logic [2*UW-1:0]             sqr_ff, sqr_in, sqi_ff, sqi_in;
   logic [ROOT_W-1:0]           m_ff, m_in;
   logic signed [SB-1:0]        nr_ff, nr_in, ni_ff, ni_in;
   logic                        rv_ff, rv_in, rrv_ff, rrv_in, rdy_ff, rdy_in;
   logic signed [SB-1:0]        ore_ff, ore_in, oim_ff, oim_in;

   logic                        mem_we;
   logic [AW-1:0]               mem_waddr, mem_raddr;
   logic [2*ACC-1:0]            mem_wdata, mem_rdata;
   logic                        root_go, root_done;
   logic [ROOT_W-1:0]           root;
   logic                        div_go, div_done;
   logic [DW-1:0]               div_num, div_q;
   logic [ROOT_W-1:0]           div_den;

   logic                        in_store, in_band;
   logic [MW-1:0]               mag_r, mag_i, mag_or;
   logic [SW-1:0]               shamt;
   logic [7:0]                  fc_next;
   logic signed [ACC-1:0]       rd_re, rd_im;

   assign in_store = 32'(bin_ff) < SPECTRUM_BINS;
   assign in_band  = in_store && (bin_ff <= band_ff);
   assign rd_re    = mem_rdata[2*ACC-1:ACC];
   assign rd_im    = mem_rdata[ACC-1:0];

   // magnitudes and common shift that brings both below 2^UW
   always_comb begin
      mag_r  = cr_ff[PW-1] ? MW'(-cr_ff) : MW'(cr_ff);
      mag_i  = ci_ff[PW-1] ? MW'(-ci_ff) : MW'(ci_ff);
      mag_or = mag_r | mag_i;
      shamt  = '0;
      for (int k = 0; k < MW; k++) begin
         if (mag_or[k] && k > UW - 1) begin
            shamt = SW'(k - (UW - 1));
         end
      end
   end

   // sequencer and datapath
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      last_in  = last_ff;
      bin_in   = bin_ff;
      ar_in    = ar_ff;
      ai_in    = ai_ff;
      br_in    = br_ff;
      bi_in    = bi_ff;
      band_in  = band_ff;
      avgf_in  = avgf_ff;
      fc_in    = fc_ff;
      accr_in  = accr_ff;
      acci_in  = acci_ff;
      p1_in    = p1_ff;
      p2_in    = p2_ff;
      p3_in    = p3_ff;
      p4_in    = p4_ff;
      cr_in    = cr_ff;
      ci_in    = ci_ff;
      ur_in    = ur_ff;
      ui_in    = ui_ff;
      sqr_in   = sqr_ff;
      sqi_in   = sqi_ff;
      m_in     = m_ff;
      nr_in    = nr_ff;
      ni_in    = ni_ff;
      rv_in    = 1'b0;
      rrv_in   = rrv_ff;
      rdy_in   = rdy_ff;
      ore_in   = ore_ff;
      oim_in   = oim_ff;
      mem_we    = 1'b0;
      mem_waddr = AW'(bin_ff);
      mem_wdata = '0;
      mem_raddr = AW'(req_bin_index);
      root_go   = 1'b0;
      div_go    = 1'b0;
      div_num   = '0;
      div_den   = m_ff;
      fc_next   = fc_ff;

      // configuration writes
      if (csr_we) begin
         case (csr_index)
            CSR_BAND_LIMIT: band_in = csr_data;
            CSR_AVG_FRAMES: avgf_in = csr_data[7:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + AW'(1);
            if (32'(clr_ff) == SPECTRUM_BINS - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               last_in  = req_last_bin;
               bin_in   = req_bin_index;
               ar_in    = req_first_re;
               ai_in    = req_first_im;
               br_in    = req_second_re;
               bi_in    = req_second_im;
               state_in = req_kind ? ST_RD_CHK : ST_MUL;
            end
         end
         ST_MUL: begin
            accr_in  = rd_re;
            acci_in  = rd_im;
            p1_in    = ar_ff * br_ff;
            p2_in    = ai_ff * bi_ff;
            p3_in    = ai_ff * br_ff;
            p4_in    = ar_ff * bi_ff;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cr_in    = PW'(p1_ff) + PW'(p2_ff);
            ci_in    = PW'(p3_ff) - PW'(p4_ff);
            state_in = ST_NORM;
         end
         ST_NORM: begin
            ur_in = UW'(mag_r >> shamt);
            ui_in = UW'(mag_i >> shamt);
            nr_in = '0;
            ni_in = '0;
            if (in_band && (cr_ff != '0 || ci_ff != '0)) begin
               state_in = ST_SQ;
            end else begin
               state_in = ST_ACC_WR;
            end
         end
         ST_SQ: begin
            sqr_in   = ur_ff * ur_ff;
            sqi_in   = ui_ff * ui_ff;
            state_in = ST_ROOT_GO;
         end
         ST_ROOT_GO: begin
            root_go  = 1'b1;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (root_done) begin
               m_in     = (root == '0) ? ROOT_W'(1) : root;
               div_go   = 1'b1;
               div_den  = (root == '0) ? ROOT_W'(1) : root;
               div_num  = (DW'(ur_ff) << (SB - 1)) + DW'(div_den >> 1);
               state_in = ST_DIV_RE;
            end
         end
         ST_DIV_RE: begin
            if (div_done) begin
               nr_in    = clamp_q(div_q, cr_ff[PW-1]);
               div_go   = 1'b1;
               div_num  = (DW'(ui_ff) << (SB - 1)) + DW'(m_ff >> 1);
               state_in = ST_DIV_IM;
            end
         end
         ST_DIV_IM: begin
            if (div_done) begin
               ni_in    = clamp_q(div_q, ci_ff[PW-1]);
               state_in = ST_ACC_WR;
            end
         end
         ST_ACC_WR: begin
            mem_we    = in_band;
            mem_wdata = {sat_add(accr_ff, nr_ff), sat_add(acci_ff, ni_ff)};
            if (last_ff && fc_ff != 8'hFF) begin
               fc_next = fc_ff + 8'd1;
            end
            fc_in    = fc_next;
            rv_in    = 1'b1;
            rrv_in   = 1'b0;
            ore_in   = '0;
            oim_in   = '0;
            rdy_in   = fc_next >= avgf_ff;
            state_in = ST_IDLE;
         end
         ST_RD_CHK: begin
            accr_in = rd_re;
            acci_in = rd_im;
            nr_in   = '0;
            ni_in   = '0;
            div_den = ROOT_W'(fc_ff);
            if (fc_ff < avgf_ff) begin
               rv_in    = 1'b1;
               rrv_in   = 1'b0;
               ore_in   = '0;
               oim_in   = '0;
               rdy_in   = 1'b0;
               state_in = ST_IDLE;
            end else if (in_band && fc_ff != 8'd0) begin
               div_go   = 1'b1;
               div_num  = abs_acc(rd_re, fc_ff);
               state_in = ST_RD_DIV_RE;
            end else begin
               state_in = ST_RD_WR;
            end
         end
         ST_RD_DIV_RE: begin
            div_den = ROOT_W'(fc_ff);
            if (div_done) begin
               nr_in    = clamp_q(div_q, accr_ff[ACC-1]);
               div_go   = 1'b1;
               div_num  = abs_acc(acci_ff, fc_ff);
               state_in = ST_RD_DIV_IM;
            end
         end
         ST_RD_DIV_IM: begin
            if (div_done) begin
               ni_in    = clamp_q(div_q, acci_ff[ACC-1]);
               state_in = ST_RD_WR;
            end
         end
         ST_RD_WR: begin
            mem_we   = in_store;
            fc_next  = last_ff ? 8'd0 : fc_ff;
            fc_in    = fc_next;
            rv_in    = 1'b1;
            rrv_in   = 1'b1;
            ore_in   = nr_ff;
            oim_in   = ni_ff;
            rdy_in   = fc_next >= avgf_ff;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         band_ff  <= BAND_LIMIT_RST;
         avgf_ff  <= AVG_FRAMES_RST;
         fc_ff    <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         band_ff  <= band_in;
         avgf_ff  <= avgf_in;
         fc_ff    <= fc_in;
         rv_ff    <= rv_in;
      end
      last_ff <= last_in;
      bin_ff  <= bin_in;
      ar_ff   <= ar_in;
      ai_ff   <= ai_in;
      br_ff   <= br_in;
      bi_ff   <= bi_in;
      accr_ff <= accr_in;
      acci_ff <= acci_in;
      p1_ff   <= p1_in;
      p2_ff   <= p2_in;
      p3_ff   <= p3_in;
      p4_ff   <= p4_in;
      cr_ff   <= cr_in;
      ci_ff   <= ci_in;
      ur_ff   <= ur_in;
      ui_ff   <= ui_in;
      sqr_ff  <= sqr_in;
      sqi_ff  <= sqi_in;
      m_ff    <= m_in;
      nr_ff   <= nr_in;
      ni_ff   <= ni_in;
      rrv_ff  <= rrv_in;
      rdy_ff  <= rdy_in;
      ore_ff  <= ore_in;
      oim_ff  <= oim_in;
   end

   pcsa_ram #(.WIDTH(2 * ACC), .DEPTH(SPECTRUM_BINS)) u_acc_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   pcsa_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .go       (root_go),
      .radicand (RAD_W'(sqr_ff) + RAD_W'(sqi_ff)),
      .done     (root_done),
      .root     (root)
   );

   pcsa_div #(.DW(DW), .VW(ROOT_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   assign busy           = state_ff != ST_IDLE;
   assign rsp_valid      = rv_ff;
   assign rsp_avg_re     = ore_ff;
   assign rsp_avg_im     = oim_ff;
   assign rsp_read_valid = rrv_ff;
   assign rsp_ready_res  = rdy_ff;
endmodule

// ----- hdl/pcsa_checker.sv -----
module pcsa_checker #(
   parameter int SAMPLE_BITS = pcsa_pkg::SAMPLE_BITS_DEF
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_valid,
   input logic                   rsp_read_valid,
   input logic [SAMPLE_BITS-1:0] rsp_avg_re,
   input logic [SAMPLE_BITS-1:0] rsp_avg_im
);
   // a result beat closes an item that was in flight
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result beat without an item in flight");

   // an accepted item holds the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   // one beat per item
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result beat repeated");

   // unserved items report zero values
   a_zero_unserved: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_read_valid |-> rsp_avg_re == '0 && rsp_avg_im == '0)
      else $error("unserved result carries a value");
endmodule

bind phat_cross_spectrum_accumulator pcsa_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_pcsa_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_read_valid (rsp_read_valid),
   .rsp_avg_re     (rsp_avg_re),
   .rsp_avg_im     (rsp_avg_im)
);

// ----- dv/tb_top.sv -----
module tb_top;
   import pcsa_pkg::*;

   localparam logic KIND_ACC  = 1'b0;
   localparam logic KIND_READ = 1'b1;
   localparam int   NBINS     = SPECTRUM_BINS_DEF;
   localparam longint ACC_MAX = 64'sd8388607;
   localparam int   TAIL_CYCLES = 300;

   typedef struct packed {
      logic              kind;
      logic [8:0]        bin_index;
      logic signed [15:0] first_re;
      logic signed [15:0] first_im;
      logic signed [15:0] second_re;
      logic signed [15:0] second_im;
      logic              last_bin;
   } bin_item_type;

   typedef struct packed {
      logic signed [15:0] avg_re;
      logic signed [15:0] avg_im;
      logic              read_valid;
      logic              ready_res;
   } bin_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_kind = 1'b0;
   logic [8:0] req_bin_index = '0;
   logic signed [15:0] req_first_re = '0;
   logic signed [15:0] req_first_im = '0;
   logic signed [15:0] req_second_re = '0;
   logic signed [15:0] req_second_im = '0;
   logic req_last_bin = 1'b0;
   logic rsp_valid;
   logic signed [15:0] rsp_avg_re;
   logic signed [15:0] rsp_avg_im;
   logic rsp_read_valid;
   logic rsp_ready_res;
   logic csr_we = 1'b0;
   logic csr_index = 1'b0;
   logic [8:0] csr_data = '0;

   phat_cross_spectrum_accumulator u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_bin_index(req_bin_index),
      .req_first_re(req_first_re), .req_first_im(req_first_im),
      .req_second_re(req_second_re), .req_second_im(req_second_im),
      .req_last_bin(req_last_bin),
      .rsp_valid(rsp_valid), .rsp_avg_re(rsp_avg_re), .rsp_avg_im(rsp_avg_im),
      .rsp_read_valid(rsp_read_valid), .rsp_ready_res(rsp_ready_res),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // spectrum state mirrored by the predictor
   longint     sum_re [NBINS];
   longint     sum_im [NBINS];
   int unsigned frames_in;
   int unsigned band_limit;
   int unsigned frames_needed;

   bin_item_type   pending_items[$];
   bin_result_type expected_bins[$];
   int  mismatch_count = 0;
   int  beats_checked = 0;
   int  served_reads = 0;
   int  csr_writes = 0;
   bit  no_idle = 1'b0;
   int  gap = 0;

   function automatic longint unsigned floor_sqrt(longint unsigned x);
      longint unsigned r = 0;
      longint unsigned b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // signed quotient, rounded half away from zero, clamped to Q1.15
   function automatic longint round_div_q15(longint num, longint unsigned den);
      longint unsigned mag = (num < 0) ? longint'(-num) : longint'(num);
      longint unsigned q = (mag + den / 2) / den;
      longint v;
      if (q > 65536) q = 65536;
      v = (num < 0) ? -longint'(q) : longint'(q);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v;
   endfunction

   function automatic longint clamp_acc(longint v);
      if (v > ACC_MAX) return ACC_MAX;
      if (v < -ACC_MAX - 1) return -ACC_MAX - 1;
      return v;
   endfunction

   // compute the result beat of one item and advance the mirrored state
   function automatic bin_result_type predict_bin(bin_item_type it);
      bin_result_type res = '0;
      int unsigned b = it.bin_index;
      bit in_store = b < NBINS;
      bit in_band = in_store && b <= band_limit;
      longint ar = it.first_re, ai = it.first_im;
      longint br = it.second_re, bi = it.second_im;
      longint cr, ci, nr, ni;
      longint unsigned ur, ui, m;
      if (it.kind == KIND_ACC) begin
         cr = ar * br + ai * bi;
         ci = ai * br - ar * bi;
         if (in_band && (cr != 0 || ci != 0)) begin
            ur = (cr < 0) ? longint'(-cr) : longint'(cr);
            ui = (ci < 0) ? longint'(-ci) : longint'(ci);
            while (ur >= (64'd1 << 31) || ui >= (64'd1 << 31)) begin
               ur >>= 1;
               ui >>= 1;
            end
            m = floor_sqrt(ur * ur + ui * ui);
            if (m == 0) m = 1;
            nr = round_div_q15((cr < 0) ? -longint'(ur << 15) : longint'(ur << 15), m);
            ni = round_div_q15((ci < 0) ? -longint'(ui << 15) : longint'(ui << 15), m);
            sum_re[b] = clamp_acc(sum_re[b] + nr);
            sum_im[b] = clamp_acc(sum_im[b] + ni);
         end
         if (it.last_bin && frames_in < 255) frames_in++;
      end else if (frames_in >= frames_needed) begin
         res.read_valid = 1'b1;
         if (in_store) begin
            if (in_band && frames_in != 0) begin
               res.avg_re = round_div_q15(sum_re[b], frames_in);
               res.avg_im = round_div_q15(sum_im[b], frames_in);
            end
            sum_re[b] = 0;
            sum_im[b] = 0;
         end
         if (it.last_bin) frames_in = 0;
      end
      res.ready_res = frames_in >= frames_needed;
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      mismatch_count++;
   endtask

   // feed items from the pending queue, with random idle bursts
   always @(posedge clock) begin
      bit fire;
      bin_item_type it;
      fire = start && !busy;
      if (reset) begin
         start <= 1'b0;
         gap <= 0;
      end else begin
         if (fire) void'(pending_items.pop_front());
         if (start && !fire) begin
            // hold the beat until taken
         end else if (gap > 0) begin
            gap <= gap - 1;
            start <= 1'b0;
         end else if (pending_items.size() == 0) begin
            start <= 1'b0;
         end else if (!no_idle && $urandom_range(0, 5) == 0) begin
            gap <= $urandom_range(0, 8);
            start <= 1'b0;
         end else begin
            it = pending_items[0];
            start <= 1'b1;
            req_kind <= it.kind;
            req_bin_index <= it.bin_index;
            req_first_re <= it.first_re;
            req_first_im <= it.first_im;
            req_second_re <= it.second_re;
            req_second_im <= it.second_im;
            req_last_bin <= it.last_bin;
         end
      end
   end

   // check result beats, then predict the beat just taken
   always @(posedge clock) begin
      bin_item_type it;
      bin_result_type want;
      if (!reset) begin
         if (csr_we) begin
            if (csr_index == CSR_BAND_LIMIT) band_limit = csr_data;
            else frames_needed = csr_data[7:0];
         end
         if (rsp_valid) begin
            beats_checked++;
            if (expected_bins.size() == 0) begin
               report_mismatch("unexpected beat", 1, 0);
            end else begin
               want = expected_bins.pop_front();
               if (rsp_avg_re !== want.avg_re)
                  report_mismatch("avg_re", rsp_avg_re, want.avg_re);
               if (rsp_avg_im !== want.avg_im)
                  report_mismatch("avg_im", rsp_avg_im, want.avg_im);
               if (rsp_read_valid !== want.read_valid)
                  report_mismatch("read_valid", rsp_read_valid, want.read_valid);
               if (rsp_ready_res !== want.ready_res)
                  report_mismatch("ready_res", rsp_ready_res, want.ready_res);
               if (want.read_valid) served_reads++;
            end
         end
         if (start && !busy) begin
            it = '{req_kind, req_bin_index, req_first_re, req_first_im,
                   req_second_re, req_second_im, req_last_bin};
            expected_bins.push_back(predict_bin(it));
         end
      end
   end

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'sh0000;
         3: return 16'sh0001;
         4: return 16'shffff;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic push_item(logic kind, int unsigned bin, logic last,
                            logic signed [15:0] a_re, logic signed [15:0] a_im,
                            logic signed [15:0] b_re, logic signed [15:0] b_im);
      bin_item_type it;
      it = '{kind, 9'(bin), a_re, a_im, b_re, b_im, last};
      pending_items.push_back(it);
   endtask

   task automatic push_random_acc(int unsigned bin, logic last);
      push_item(KIND_ACC, bin, last, pick_sample(), pick_sample(), pick_sample(),
                pick_sample());
   endtask

   // wait until every beat is back and the block has settled
   task automatic drain();
      do @(posedge clock);
      while (pending_items.size() != 0 || expected_bins.size() != 0 || start);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [8:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      csr_writes++;
   endtask

   // frames over a small run of bins, then a readout of the same bins
   task automatic push_frames(int unsigned nframes, bit with_noise);
      int unsigned base, nb, k, f;
      base = $urandom_range(0, 250);
      if ($urandom_range(0, 9) == 0) base = 250 + $urandom_range(0, 6);
      nb = $urandom_range(1, 6);
      for (f = 0; f < nframes; f++)
         for (k = 0; k < nb; k++) begin
            push_random_acc(base + k, k == nb - 1);
            if (with_noise && $urandom_range(0, 9) == 0)
               push_item(KIND_READ, $urandom_range(0, 511), 1'b0, pick_sample(),
                         pick_sample(), pick_sample(), pick_sample());
         end
      for (k = 0; k < nb; k++)
         push_item(KIND_READ, base + k, k == nb - 1, pick_sample(), pick_sample(),
                   pick_sample(), pick_sample());
   endtask

   initial begin
      int unsigned i, p;
      for (i = 0; i < NBINS; i++) begin
         sum_re[i] = 0;
         sum_im[i] = 0;
      end
      frames_in = 0;
      band_limit = BAND_LIMIT_RST;
      frames_needed = AVG_FRAMES_RST;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock); while (busy);

      // directed: unserved reads, field extremes, zero product, edge bins
      push_item(KIND_READ, 3, 1'b1, 0, 0, 0, 0);
      push_item(KIND_ACC, 0, 1'b0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      push_item(KIND_ACC, 1, 1'b0, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000);
      push_item(KIND_ACC, 2, 1'b0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      push_item(KIND_ACC, 3, 1'b0, 0, 0, 16'sh1234, 16'sh4321);
      push_item(KIND_ACC, 4, 1'b0, 16'sh0001, 16'sh0000, 16'sh0000, 16'sh0001);
      push_item(KIND_ACC, 256, 1'b0, 16'sh4000, 16'shc000, 16'sh2000, 16'sh6000);
      push_item(KIND_ACC, 300, 1'b0, 16'sh4000, 16'sh4000, 16'sh4000, 16'sh4000);
      push_item(KIND_ACC, 511, 1'b1, 16'shffff, 16'sh0001, 16'sh0001, 16'shffff);
      for (i = 0; i < 3; i++)
         push_item(KIND_ACC, 0, 1'b1, 16'sh8000, 16'sh0000, 16'sh8000, 16'sh7fff);
      push_item(KIND_READ, 0, 1'b0, 0, 0, 0, 0);
      push_item(KIND_READ, 1, 1'b0, 0, 0, 0, 0);
      push_item(KIND_READ, 2, 1'b0, 0, 0, 0, 0);
      push_item(KIND_READ, 3, 1'b0, 0, 0, 0, 0);
      push_item(KIND_READ, 256, 1'b0, 0, 0, 0, 0);
      push_item(KIND_READ, 300, 1'b0, 0, 0, 0, 0);
      push_item(KIND_READ, 4, 1'b1, 0, 0, 0, 0);
      push_item(KIND_READ, 4, 1'b0, 0, 0, 0, 0);
      drain();

      // lowest band limit and a single-frame average
      write_csr(CSR_BAND_LIMIT, 9'd0);
      write_csr(CSR_AVG_FRAMES, 9'd1);
      push_random_acc(0, 1'b0);
      push_random_acc(1, 1'b1);
      push_item(KIND_READ, 0, 1'b0, 0, 0, 0, 0);
      push_item(KIND_READ, 1, 1'b1, 0, 0, 0, 0);
      drain();

      // frame count and accumulator saturation on one bin
      write_csr(CSR_BAND_LIMIT, 9'd256);
      write_csr(CSR_AVG_FRAMES, 9'd255);
      for (i = 0; i < 262; i++)
         push_item(KIND_ACC, 7, 1'b1, 16'sh7fff, 16'sh0000, 16'sh7fff, 16'sh0000);
      push_item(KIND_READ, 7, 1'b1, 0, 0, 0, 0);
      drain();

      // random phases over a spread of settings
      for (p = 0; p < 8; p++) begin
         case (p)
            0: write_csr(CSR_AVG_FRAMES, 9'd1);
            1: write_csr(CSR_BAND_LIMIT, 9'($urandom_range(0, 256)));
            2: write_csr(CSR_AVG_FRAMES, 9'($urandom_range(2, 6)));
            3: write_csr(CSR_BAND_LIMIT, 9'd256);
            default: begin
               write_csr(CSR_BAND_LIMIT, 9'($urandom_range(0, 256)));
               write_csr(CSR_AVG_FRAMES, 9'($urandom_range(1, 5)));
            end
         endcase
         if (p == 7) no_idle = 1'b1;
         for (i = 0; i < 3; i++)
            push_frames($urandom_range(frames_needed, frames_needed + 2), 1'b1);
         for (i = 0; i < 10; i++)
            if ($urandom_range(0, 1)) push_random_acc($urandom_range(0, 511), 1'($urandom));
            else push_item(KIND_READ, $urandom_range(0, 511), 1'($urandom), pick_sample(),
                           pick_sample(), pick_sample(), pick_sample());
         drain();
      end

      $display("checked %0d result beats, %0d served reads, %0d register writes",
               beats_checked, served_reads, csr_writes);
      if (mismatch_count == 0) begin
         $display("PASS phat_cross_spectrum_accumulator");
      end else begin
         $display("FAIL phat_cross_spectrum_accumulator");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("FAIL phat_cross_spectrum_accumulator");
      $finish;
   end

endmodule
